### hdl/ipv4cs_pkg.sv
// Package for the IPv4 checksum offload block: transaction types, status and
// kind codes, and the ones-complement add function.
// No dependencies.
`default_nettype none

package ipv4cs_pkg;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] header_checksum;
        logic        header_checksum_valid;
        logic [15:0] transport_checksum;
        logic [1:0]  transport_kind;
        logic [5:0]  header_length;
        logic [15:0] total_length;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic        overflow;
        logic [15:0] length;
        logic [7:0]  first_byte;
        logic [7:0]  protocol_byte;
        logic [15:0] header_sum;
        logic [15:0] pseudo_sum;
        logic [15:0] payload_sum;
    } t_pkt_snap;

    localparam logic MODE_TX = 1'b0;
    localparam logic MODE_RX = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OUT_OF_BNDS = 3'd1;
    localparam logic [2:0] ST_BAD_HDR_LEN = 3'd2;
    localparam logic [2:0] ST_SHORT       = 3'd3;
    localparam logic [2:0] ST_HDR_OVERRUN = 3'd4;
    localparam logic [2:0] ST_BAD_CSUM    = 3'd5;
    localparam logic [2:0] ST_TOO_LONG    = 3'd6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ICMP = 2'd1;
    localparam logic [1:0] KIND_UDP  = 2'd2;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [3:0] IP_VERSION = 4'd4;

    localparam int IDX_PROTOCOL  = 9;
    localparam int IDX_CSUM_HI   = 10;
    localparam int IDX_CSUM_LO   = 11;
    localparam int IDX_SRC_ADDR  = 12;
    localparam int MIN_HDR_BYTES = 20;
    localparam int MIN_TX_BYTES  = 2;
    localparam int TRANSPORT_HDR = 8;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ipv4cs_accum.sv
// Input register and per-byte accumulator: keeps the running ones-complement
// sums for one packet and registers a snapshot of them at the last byte.
// Depends on ipv4cs_pkg.
`default_nettype none

module ipv4cs_accum #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_mode,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  ipv4cs_pkg::t_in_item  i_in_item,
    output logic                  o_snap_valid,
    input  wire                   i_snap_ready,
    output ipv4cs_pkg::t_pkt_snap o_snap
);

    logic                   r_in_valid;
    ipv4cs_pkg::t_in_item   r_in;
    logic                   r_snap_valid;
    ipv4cs_pkg::t_pkt_snap  r_snap;
    ipv4cs_pkg::t_pkt_snap  n_snap;

    logic [LENGTH_BITS-1:0] r_byte_index, n_byte_index;
    logic [15:0]            r_header_sum, n_header_sum;
    logic [15:0]            r_pseudo_sum, n_pseudo_sum;
    logic [15:0]            r_payload_sum, n_payload_sum;
    logic [7:0]             r_first_byte, n_first_byte;
    logic [7:0]             r_protocol_byte, n_protocol_byte;
    logic                   r_overflow, n_overflow;

    logic snap_free;
    logic acc_fire;

    assign snap_free    = !r_snap_valid || i_snap_ready;
    assign acc_fire     = r_in_valid && (!r_in.last_byte || snap_free);
    assign o_in_ready   = !r_in_valid || acc_fire;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        logic [7:0]             b;
        logic [LENGTH_BITS-1:0] idx;
        logic [LENGTH_BITS-1:0] hs;
        logic [15:0]            word;
        logic                   skip;

        b    = r_in.packet_byte;
        idx  = r_byte_index;
        hs   = '0;
        word = idx[0] ? {8'h00, b} : {b, 8'h00};
        skip = 1'b0;

        n_byte_index    = r_byte_index;
        n_header_sum    = r_header_sum;
        n_pseudo_sum    = r_pseudo_sum;
        n_payload_sum   = r_payload_sum;
        n_first_byte    = r_first_byte;
        n_protocol_byte = r_protocol_byte;
        n_overflow      = r_overflow;

        if (!r_overflow && (idx == '1)) begin
            n_overflow = 1'b1;
        end else if (!r_overflow) begin
            if (idx == '0) begin
                n_first_byte = b;
            end
            if (idx == LENGTH_BITS'(ipv4cs_pkg::IDX_PROTOCOL)) begin
                n_protocol_byte = b;
            end
            hs = LENGTH_BITS'({n_first_byte[3:0], 2'b00});
            if (idx < hs) begin
                if (!(i_mode == ipv4cs_pkg::MODE_TX &&
                      (idx == LENGTH_BITS'(ipv4cs_pkg::IDX_CSUM_HI) ||
                       idx == LENGTH_BITS'(ipv4cs_pkg::IDX_CSUM_LO)))) begin
                    n_header_sum = ipv4cs_pkg::oc_add(r_header_sum, word);
                end
            end else begin
                if (n_protocol_byte == ipv4cs_pkg::PROTO_ICMP &&
                    (idx == hs + LENGTH_BITS'(2) || idx == hs + LENGTH_BITS'(3))) begin
                    skip = 1'b1;
                end
                if (n_protocol_byte == ipv4cs_pkg::PROTO_UDP &&
                    (idx == hs + LENGTH_BITS'(6) || idx == hs + LENGTH_BITS'(7))) begin
                    skip = 1'b1;
                end
                if (!skip) begin
                    n_payload_sum = ipv4cs_pkg::oc_add(r_payload_sum, word);
                end
            end
            if (idx >= LENGTH_BITS'(ipv4cs_pkg::IDX_SRC_ADDR) &&
                idx < LENGTH_BITS'(ipv4cs_pkg::MIN_HDR_BYTES)) begin
                n_pseudo_sum = ipv4cs_pkg::oc_add(r_pseudo_sum, word);
            end
            n_byte_index = idx + LENGTH_BITS'(1);
        end

        n_snap.mode          = i_mode;
        n_snap.overflow      = n_overflow;
        n_snap.length        = n_overflow ? 16'({LENGTH_BITS{1'b1}}) : 16'(n_byte_index);
        n_snap.first_byte    = n_first_byte;
        n_snap.protocol_byte = n_protocol_byte;
        n_snap.header_sum    = n_header_sum;
        n_snap.pseudo_sum    = n_pseudo_sum;
        n_snap.payload_sum   = n_payload_sum;

        if (r_in.last_byte) begin
            n_byte_index    = '0;
            n_header_sum    = '0;
            n_pseudo_sum    = '0;
            n_payload_sum   = '0;
            n_first_byte    = '0;
            n_protocol_byte = '0;
            n_overflow      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_snap_valid    <= 1'b0;
            r_byte_index    <= '0;
            r_header_sum    <= '0;
            r_pseudo_sum    <= '0;
            r_payload_sum   <= '0;
            r_first_byte    <= '0;
            r_protocol_byte <= '0;
            r_overflow      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (acc_fire) begin
                r_byte_index    <= n_byte_index;
                r_header_sum    <= n_header_sum;
                r_pseudo_sum    <= n_pseudo_sum;
                r_payload_sum   <= n_payload_sum;
                r_first_byte    <= n_first_byte;
                r_protocol_byte <= n_protocol_byte;
                r_overflow      <= n_overflow;
            end
            if (acc_fire && r_in.last_byte) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (acc_fire && r_in.last_byte) begin
            r_snap <= n_snap;
        end
    end

endmodule

`default_nettype wire

### hdl/ipv4cs_final.sv
// Result stage: turns a packet snapshot into checksums and status and holds
// the result in the output register.
// Depends on ipv4cs_pkg.
`default_nettype none

module ipv4cs_final (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_snap_valid,
    output logic                  o_snap_ready,
    input  ipv4cs_pkg::t_pkt_snap i_snap,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output ipv4cs_pkg::t_out_item o_out_item
);

    logic                  r_out_valid;
    ipv4cs_pkg::t_out_item r_out;
    ipv4cs_pkg::t_out_item n_out;
    logic                  out_free;

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_snap_ready = out_free;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out;

    always_comb begin
        logic [5:0]  hs;
        logic [15:0] len;
        logic [15:0] diff;
        logic [17:0] usum;
        logic [16:0] ufold;
        logic [15:0] ures;

        hs    = {i_snap.first_byte[3:0], 2'b00};
        len   = i_snap.length;
        diff  = len - 16'(hs);
        usum  = 18'(i_snap.pseudo_sum) + 18'(ipv4cs_pkg::PROTO_UDP) + 18'(diff) +
                18'(i_snap.payload_sum);
        ufold = 17'(usum[15:0]) + 17'(usum[17:16]);
        ures  = ~(ufold[15:0] + 16'(ufold[16]));

        n_out.header_checksum       = '0;
        n_out.header_checksum_valid = 1'b0;
        n_out.transport_checksum    = '0;
        n_out.transport_kind        = ipv4cs_pkg::KIND_NONE;
        n_out.header_length         = hs;
        n_out.total_length          = len;
        n_out.status                = ipv4cs_pkg::ST_OK;

        if (i_snap.overflow) begin
            n_out.status = ipv4cs_pkg::ST_TOO_LONG;
        end else if (i_snap.mode == ipv4cs_pkg::MODE_TX) begin
            if (len < 16'(ipv4cs_pkg::MIN_TX_BYTES)) begin
                n_out.status = ipv4cs_pkg::ST_OUT_OF_BNDS;
            end else if (hs < 6'(ipv4cs_pkg::MIN_HDR_BYTES)) begin
                n_out.status = ipv4cs_pkg::ST_BAD_HDR_LEN;
            end else if (16'(hs) > len) begin
                n_out.status = ipv4cs_pkg::ST_OUT_OF_BNDS;
            end else if (i_snap.first_byte[7:4] == ipv4cs_pkg::IP_VERSION) begin
                n_out.header_checksum_valid = 1'b1;
                n_out.header_checksum       = ~i_snap.header_sum;
                if (17'(len) >= 17'(hs) + 17'(ipv4cs_pkg::TRANSPORT_HDR)) begin
                    if (i_snap.protocol_byte == ipv4cs_pkg::PROTO_ICMP) begin
                        n_out.transport_kind     = ipv4cs_pkg::KIND_ICMP;
                        n_out.transport_checksum = ~i_snap.payload_sum;
                    end else if (i_snap.protocol_byte == ipv4cs_pkg::PROTO_UDP) begin
                        n_out.transport_kind     = ipv4cs_pkg::KIND_UDP;
                        n_out.transport_checksum = (ures == 16'h0000) ? 16'hFFFF : ures;
                    end
                end
            end
        end else begin
            if (len < 16'(ipv4cs_pkg::MIN_HDR_BYTES)) begin
                n_out.status = ipv4cs_pkg::ST_SHORT;
            end else if (16'(hs) > len) begin
                n_out.status = ipv4cs_pkg::ST_HDR_OVERRUN;
            end else begin
                n_out.header_checksum_valid = 1'b1;
                n_out.header_checksum       = ~i_snap.header_sum;
                if (i_snap.header_sum != 16'hFFFF) begin
                    n_out.status = ipv4cs_pkg::ST_BAD_CSUM;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && i_snap_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### hdl/ipv4_checksum_offload_top.sv
// Path: a packet's result passes the input, snapshot and output registers in turn.
// Throughput: one byte per cycle; one result per packet, the last byte of a packet
// waits only while snapshot and output registers are full and i_out_ready is low.
// Reset clears the mode register to transmit, the packet sums and all valid flags.
// Top level of the IPv4 checksum offload block; depends on ipv4cs_pkg,
// ipv4cs_accum and ipv4cs_final.
`default_nettype none

module ipv4_checksum_offload_top #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire                   i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  ipv4cs_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output ipv4cs_pkg::t_out_item o_out_item
);

    logic                  r_mode;
    logic                  snap_valid;
    logic                  snap_ready;
    ipv4cs_pkg::t_pkt_snap snap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ipv4cs_pkg::MODE_TX;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    ipv4cs_accum #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    ipv4cs_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

### hdl/ipv4cs_checker.sv
// Port-level checker for the IPv4 checksum offload top level, with its bind.
// Depends on ipv4cs_pkg and ipv4_checksum_offload_top.
`default_nettype none

module ipv4cs_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input ipv4cs_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("Result transaction changed before it was taken.");

    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.transport_kind != ipv4cs_pkg::KIND_NONE) |->
        (o_out_item.header_checksum_valid && o_out_item.status == ipv4cs_pkg::ST_OK))
        else $error("Transport checksum given without a valid header.");

    a_udp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.transport_kind == ipv4cs_pkg::KIND_UDP) |->
        (o_out_item.transport_checksum != 16'h0000))
        else $error("UDP checksum of zero was sent.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.header_checksum_valid) |->
        (o_out_item.header_checksum == 16'h0000 &&
         o_out_item.transport_kind == ipv4cs_pkg::KIND_NONE))
        else $error("Checksum fields are set on an unusable header.");

endmodule

bind ipv4_checksum_offload_top ipv4cs_checker u_checker (.*);

`default_nettype wire
